FILE: sv/dae_pkg.sv
// types, constants and helper functions shared by the dihedral angle engine
package dae_pkg;

  localparam int IDX_W      = 11;
  localparam int COORD_W    = 21;
  localparam int ANGLE_W    = 17;
  localparam int CORDIC_N   = 23;
  localparam int S_TDATA_W  = 120;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;
  localparam int POINT_W    = 3 * COORD_W;

  localparam logic signed [24:0] Z_RIGHT         = 25'sd5898240;
  localparam logic signed [24:0] FULL_Z          = 25'sd11796480;
  localparam logic [16:0]        RIGHT_ANGLE_OUT = 17'd23040;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // one queued item after classification
  typedef struct packed {
    cmd_e                      cmd;
    logic                      wr_ok;
    logic                      inv;
    logic [IDX_W-1:0]          pidx;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
    logic [IDX_W-1:0]          i1;
    logic [IDX_W-1:0]          i2;
    logic [IDX_W-1:0]          i3;
    logic [IDX_W-1:0]          i4;
  } cmd_t;

  // flags travelling alongside a query through the back end
  typedef struct packed {
    logic vld;
    logic inv;
    logic deg;
    logic neg;
  } meta_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [22:0] atan_lut(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0:    r = 23'd2949120;
      5'd1:    r = 23'd1740967;
      5'd2:    r = 23'd919879;
      5'd3:    r = 23'd466945;
      5'd4:    r = 23'd234379;
      5'd5:    r = 23'd117304;
      5'd6:    r = 23'd58666;
      5'd7:    r = 23'd29335;
      5'd8:    r = 23'd14668;
      5'd9:    r = 23'd7334;
      5'd10:   r = 23'd3667;
      5'd11:   r = 23'd1833;
      5'd12:   r = 23'd917;
      5'd13:   r = 23'd458;
      5'd14:   r = 23'd229;
      5'd15:   r = 23'd115;
      5'd16:   r = 23'd57;
      5'd17:   r = 23'd29;
      5'd18:   r = 23'd14;
      5'd19:   r = 23'd7;
      5'd20:   r = 23'd4;
      5'd21:   r = 23'd2;
      5'd22:   r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // position of the highest set bit plus one, zero for an empty word
  function automatic logic [5:0] bitlen44(input logic [43:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 44; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

FILE: sv/dae_ram.sv
// generic simple dual-read RAM with registered read data
module dae_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr0_i,
  input  logic [AW-1:0] raddr1_i,
  output logic [W-1:0]  rdata0_o,
  output logic [W-1:0]  rdata1_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

FILE: sv/dae_front.sv
// input side: unpacks and classifies items, holds atom count, short item queue
module dae_front #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dae_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,
  input  logic                          cfg_we_i,
  input  logic [dae_pkg::IDX_W-1:0]     cfg_wdata_i,
  output logic                          head_valid_o,
  output dae_pkg::cmd_t                 head_o,
  input  logic                          pop_i
);
  import dae_pkg::*;

  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  logic [IDX_W-1:0] atom_count_q;
  cmd_t             q_mem_q [QD];
  logic [QA-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QA:0]      cnt_q, cnt_d;
  cmd_t             item;
  logic             push;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] cnt);
    return (idx != '0) && (idx <= cnt) && (32'(idx) <= MAX_POINTS);
  endfunction

  always_comb begin
    item.cmd   = cmd_e'(s_axis_tuser_i);
    item.pidx  = s_axis_tdata_i[10:0];
    item.x     = $signed(s_axis_tdata_i[31:11]);
    item.y     = $signed(s_axis_tdata_i[52:32]);
    item.z     = $signed(s_axis_tdata_i[73:53]);
    item.i1    = s_axis_tdata_i[84:74];
    item.i2    = s_axis_tdata_i[95:85];
    item.i3    = s_axis_tdata_i[106:96];
    item.i4    = s_axis_tdata_i[117:107];
    item.wr_ok = (item.pidx != '0) && (32'(item.pidx) <= MAX_POINTS);
    item.inv   = !(idx_ok(item.i1, atom_count_q) && idx_ok(item.i2, atom_count_q) &&
                   idx_ok(item.i3, atom_count_q) && idx_ok(item.i4, atom_count_q));
  end

  assign s_axis_tready_o = (cnt_q != (QA+1)'(QD));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign head_valid_o    = (cnt_q != '0);
  assign head_o          = q_mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= '0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) atom_count_q <= cfg_wdata_i;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

FILE: sv/dae_back.sv
// execution side: point store, normals, triple product, sqrt and cordic pipeline
module dae_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  dae_pkg::cmd_t                 head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [dae_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [dae_pkg::M_TUSER_W-1:0] m_axis_tuser_o
);
  import dae_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int ST_E  = 5;
  localparam int ST_F  = 6;
  localparam int SQ_N  = 32;
  localparam int NST   = 11 + SQ_N + 3 + CORDIC_N;

  logic adv, we, pop_query;
  logic [POINT_W-1:0] rda0, rda1, rdb0, rdb1;

  meta_t meta_q [NST];
  meta_t meta_nx [1:NST-1];
  logic  deg_e, neg_f;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return AW'(idx - 11'd1);
  endfunction

  function automatic logic signed [COORD_W-1:0] crd(input logic [POINT_W-1:0] p, input int k);
    return $signed(p[COORD_W*k +: COORD_W]);
  endfunction

  function automatic logic [43:0] mag44(input logic signed [44:0] n);
    return n[44] ? 44'(-n) : 44'(n);
  endfunction

  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    return v[32] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [5:0] red_shift(input logic [43:0] v);
    logic [5:0] n;
    n = bitlen44(v);
    return (n > 6'd15) ? n - 6'd15 : 6'd0;
  endfunction

  function automatic logic signed [15:0] reduce(input logic [43:0] m, input logic [5:0] s,
                                                input logic sg);
    logic [14:0] r;
    r = 15'(m >> s);
    return sg ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic logic [ANGLE_W-1:0] fin_angle(input logic signed [24:0] z, input meta_t m);
    logic signed [24:0] zc;
    logic [ANGLE_W-1:0] mg;
    zc = z;
    if (z < 0) zc = '0;
    else if (z > FULL_Z) zc = FULL_Z;
    mg = ANGLE_W'((zc + 25'sd128) >>> 8);
    if (m.deg) mg = RIGHT_ANGLE_OUT;
    if (m.neg) mg = -mg;
    if (m.inv) mg = '0;
    return mg;
  endfunction

  // whole pipeline moves together, held only by a full output register
  logic out_vld_q;
  assign adv       = !out_vld_q || m_axis_tready_i;
  assign pop_o     = head_valid_i && ((head_i.cmd == CMD_WRITE) || adv);
  assign pop_query = pop_o && (head_i.cmd == CMD_QUERY);
  assign we        = pop_o && (head_i.cmd == CMD_WRITE) && head_i.wr_ok;

  // two copies of the store give four reads a cycle while the pipeline advances
  dae_ram #(.W(POINT_W), .DEPTH(MAX_POINTS)) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (to_addr(head_i.pidx)),
    .wdata_i  ({head_i.z, head_i.y, head_i.x}),
    .re_i     (adv),
    .raddr0_i (to_addr(head_i.i1)),
    .raddr1_i (to_addr(head_i.i2)),
    .rdata0_o (rda0),
    .rdata1_o (rda1)
  );

  dae_ram #(.W(POINT_W), .DEPTH(MAX_POINTS)) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (to_addr(head_i.pidx)),
    .wdata_i  ({head_i.z, head_i.y, head_i.x}),
    .re_i     (adv),
    .raddr0_i (to_addr(head_i.i3)),
    .raddr1_i (to_addr(head_i.i4)),
    .rdata0_o (rdb0),
    .rdata1_o (rdb1)
  );

  logic signed [21:0] d1_q [3], d3_q [3], d4_q [3];
  logic signed [21:0] d1b_q [3], d1c_q [3];
  logic signed [43:0] pa1_q [3], pb1_q [3], pa2_q [3], pb2_q [3];
  logic signed [44:0] n1_q [3], n2_q [3];
  logic [43:0]        m1_q [3], m2_q [3], m1e_q [3], m2e_q [3];
  logic               sg1_q [3], sg2_q [3], sg1e_q [3], sg2e_q [3];
  logic signed [46:0] pl_q [3];
  logic signed [42:0] ph_q [3];
  logic [5:0]         s1_q, s2_q;
  logic signed [48:0] lo_q;
  logic signed [44:0] hi_q;
  logic signed [15:0] u_q [3], v_q [3];
  logic signed [31:0] pc_q [3], pcr_q [6];
  logic signed [33:0] c_q, ci_q;
  logic [31:0]        cm_q [3];
  logic [63:0]        sq_q [3];

  logic [35:0]        sr_rem_q  [SQ_N+1];
  logic [31:0]        sr_root_q [SQ_N+1];
  logic [63:0]        sr_rad_q  [SQ_N+1];
  logic signed [33:0] sr_c_q    [SQ_N+1];

  logic [31:0]        kx_q, ky_q, lx_q, ly_q;
  logic signed [24:0] kz_q, lz_q;
  logic [5:0]         lk_q;

  logic signed [44:0] cox_q [CORDIC_N+1];
  logic signed [44:0] coy_q [CORDIC_N+1];
  logic signed [24:0] coz_q [CORDIC_N+1];

  logic [ANGLE_W-1:0] out_ang_q;
  logic               out_inv_q, out_deg_q;

  assign deg_e = ((m1_q[0] | m1_q[1] | m1_q[2]) == '0) || ((m2_q[0] | m2_q[1] | m2_q[2]) == '0);

  // sign of d1 . n2 from the split partial sums
  always_comb begin
    logic signed [45:0] t;
    t     = 46'(hi_q) + 46'(lo_q >>> 24);
    neg_f = t[45];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= 22'(crd(rda0, k)) - 22'(crd(rda1, k));
        d3_q[k] <= 22'(crd(rdb0, k)) - 22'(crd(rda1, k));
        d4_q[k] <= 22'(crd(rdb1, k)) - 22'(crd(rda1, k));
      end
      // cross product terms
      pa1_q[0] <= d1_q[1] * d3_q[2];  pb1_q[0] <= d3_q[1] * d1_q[2];
      pa1_q[1] <= d3_q[0] * d1_q[2];  pb1_q[1] <= d1_q[0] * d3_q[2];
      pa1_q[2] <= d1_q[0] * d3_q[1];  pb1_q[2] <= d3_q[0] * d1_q[1];
      pa2_q[0] <= d4_q[1] * d3_q[2];  pb2_q[0] <= d3_q[1] * d4_q[2];
      pa2_q[1] <= d3_q[0] * d4_q[2];  pb2_q[1] <= d4_q[0] * d3_q[2];
      pa2_q[2] <= d4_q[0] * d3_q[1];  pb2_q[2] <= d3_q[0] * d4_q[1];
      d1b_q <= d1_q;
      for (int k = 0; k < 3; k++) begin
        n1_q[k] <= 45'(pa1_q[k]) - 45'(pb1_q[k]);
        n2_q[k] <= 45'(pa2_q[k]) - 45'(pb2_q[k]);
      end
      d1c_q <= d1b_q;
      for (int k = 0; k < 3; k++) begin
        m1_q[k]  <= mag44(n1_q[k]);
        m2_q[k]  <= mag44(n2_q[k]);
        sg1_q[k] <= n1_q[k][44];
        sg2_q[k] <= n2_q[k][44];
        pl_q[k]  <= d1c_q[k] * $signed({1'b0, n2_q[k][23:0]});
        ph_q[k]  <= d1c_q[k] * $signed(n2_q[k][44:24]);
      end
      s1_q   <= red_shift(m1_q[0] | m1_q[1] | m1_q[2]);
      s2_q   <= red_shift(m2_q[0] | m2_q[1] | m2_q[2]);
      m1e_q  <= m1_q;
      m2e_q  <= m2_q;
      sg1e_q <= sg1_q;
      sg2e_q <= sg2_q;
      lo_q   <= 49'(pl_q[0]) + 49'(pl_q[1]) + 49'(pl_q[2]);
      hi_q   <= 45'(ph_q[0]) + 45'(ph_q[1]) + 45'(ph_q[2]);
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= reduce(m1e_q[k], s1_q, sg1e_q[k]);
        v_q[k] <= reduce(m2e_q[k], s2_q, sg2e_q[k]);
        pc_q[k] <= u_q[k] * v_q[k];
      end
      pcr_q[0] <= u_q[1] * v_q[2];  pcr_q[1] <= u_q[2] * v_q[1];
      pcr_q[2] <= u_q[2] * v_q[0];  pcr_q[3] <= u_q[0] * v_q[2];
      pcr_q[4] <= u_q[0] * v_q[1];  pcr_q[5] <= u_q[1] * v_q[0];
      c_q      <= 34'(pc_q[0]) + 34'(pc_q[1]) + 34'(pc_q[2]);
      for (int k = 0; k < 3; k++) begin
        cm_q[k] <= abs33(33'(pcr_q[2*k]) - 33'(pcr_q[2*k+1]));
        sq_q[k] <= 64'(cm_q[k]) * 64'(cm_q[k]);
      end
      ci_q         <= c_q;
      sr_rad_q[0]  <= sq_q[0] + sq_q[1] + sq_q[2];
      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;
      sr_c_q[0]    <= ci_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [35:0] rr, tt;
    logic        ge;
    assign rr = {sr_rem_q[j][33:0], sr_rad_q[j][63:62]};
    assign tt = {2'b00, sr_root_q[j], 2'b01};
    assign ge = (rr >= tt);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_rem_q[j+1]  <= ge ? rr - tt : rr;
        sr_root_q[j+1] <= {sr_root_q[j][30:0], ge};
        sr_rad_q[j+1]  <= sr_rad_q[j] << 2;
        sr_c_q[j+1]    <= sr_c_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // fold into the first quadrant
      if (sr_c_q[SQ_N] < 0) begin
        kx_q <= sr_root_q[SQ_N];
        ky_q <= 32'(-sr_c_q[SQ_N]);
        kz_q <= Z_RIGHT;
      end else begin
        kx_q <= 32'(sr_c_q[SQ_N]);
        ky_q <= sr_root_q[SQ_N];
        kz_q <= '0;
      end
      lk_q     <= 6'd41 - bitlen44(44'(kx_q | ky_q));
      lx_q     <= kx_q;
      ly_q     <= ky_q;
      lz_q     <= kz_q;
      cox_q[0] <= $signed(45'(lx_q) << lk_q);
      coy_q[0] <= $signed(45'(ly_q) << lk_q);
      coz_q[0] <= lz_q;
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (coy_q[i] > 0) begin
          cox_q[i+1] <= cox_q[i] + (coy_q[i] >>> i);
          coy_q[i+1] <= coy_q[i] - (cox_q[i] >>> i);
          coz_q[i+1] <= coz_q[i] + $signed(25'(atan_lut(5'(i))));
        end else begin
          cox_q[i+1] <= cox_q[i] - (coy_q[i] >>> i);
          coy_q[i+1] <= coy_q[i] + (cox_q[i] >>> i);
          coz_q[i+1] <= coz_q[i] - $signed(25'(atan_lut(5'(i))));
        end
      end
    end
  end

  always_comb begin
    for (int k = 1; k < NST; k++) begin
      meta_nx[k] = meta_q[k-1];
    end
    meta_nx[ST_E].deg = deg_e;
    meta_nx[ST_F].neg = neg_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        meta_q[k] <= '0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      meta_q[0] <= '{vld: pop_query, inv: head_i.inv, deg: 1'b0, neg: 1'b0};
      for (int k = 1; k < NST; k++) begin
        meta_q[k] <= meta_nx[k];
      end
      out_vld_q <= meta_q[NST-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ang_q <= fin_angle(coz_q[CORDIC_N], meta_q[NST-1]);
      out_inv_q <= meta_q[NST-1].inv;
      out_deg_q <= meta_q[NST-1].deg && !meta_q[NST-1].inv;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(M_TDATA_W-ANGLE_W)'(0), out_ang_q};
  assign m_axis_tuser_o  = {out_deg_q, out_inv_q};

endmodule

FILE: sv/dihedral_angle_engine.sv
// dihedral angle engine: point store plus pipelined torsion angle unit
// Usage:
//   s_axis carries one item per handshake; tuser selects write point (0) or
//   query angle (1). A write loads a 1-based slot of the point store and
//   gives no result; a query names four points and gives one result.
//   m_axis returns the signed angle in 1/256 degree with the index_invalid
//   and degenerate flags in tuser.
//   cfg_we_i loads atom_count, the limit for query indices; write it only
//   while no query is in flight.
// Throughput: one item per cycle while m_axis is not stalled. The path from
//   the input handshake to the result runs through the 32-stage square root
//   and the 23-stage cordic of the angle pipeline.
// A four-entry item queue sits ahead of the pipeline, so input is still taken
//   while a result waits; when a held result sees m_axis_tready_i low the
//   whole pipeline holds and s_axis_tready_o drops once the queue is full.
// Reset clears atom_count, the queue and all valid flags; the point store is
//   not cleared and a slot must be written before any query reads it.
module dihedral_angle_engine #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // point_index, coord_x, coord_y, coord_z, first_index, second_index,
  // third_index, fourth_index
  input  logic [dae_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // command
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // torsion_angle
  output logic [dae_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // index_invalid, degenerate
  output logic [dae_pkg::M_TUSER_W-1:0] m_axis_tuser_o,
  input  logic                          cfg_we_i,
  input  logic [dae_pkg::IDX_W-1:0]     cfg_wdata_i
);
  import dae_pkg::*;

  cmd_t head;
  logic head_valid, pop;

  dae_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  dae_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
